// File: sv/srt_pkg.sv
// shared types and constants of the spiral route transposition block
// no dependencies; imported by every module of the block
package srt_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 11;
  localparam int ACC_W    = $clog2(CAPACITY + (1 << CFG_W));
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [IDX_W-1:0] REG_COLS = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OVF   = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LOAD  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_ACCEPT = 3'd0,
    S_SIZE   = 3'd1,
    S_WALK   = 3'd2,
    S_DRAIN  = 3'd3,
    S_FWAIT  = 3'd4,
    S_OUT    = 3'd5
  } state_t;

  typedef struct packed {
    logic load;
    logic new_msg;
    logic size_init;
    logic set_ovf;
    logic walk_init;
    logic walk_step;
    logic fetch;
    logic ready_phase;
  } cmd_t;

  typedef struct packed {
    logic ovf_now;
    logic fit;
    logic walk_last;
  } stat_bus_t;

endpackage

// File: sv/srt_ctrl.sv
// controller state machine: sequences load, sizing, spiral walk and fetch
// depends on srt_pkg
module srt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tuser,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  srt_pkg::stat_bus_t sts,
  output srt_pkg::cmd_t     cmd
);
  import srt_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   acc_in;

  assign acc_in = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCEPT;
      phase_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      S_ACCEPT: begin
        if (acc_in) begin
          if (in_tuser == OP_FETCH) begin
            state_nxt = S_FWAIT;
          end else begin
            phase_nxt = PH_LOAD;
            if (in_tlast) state_nxt = S_SIZE;
          end
        end
      end
      S_SIZE: begin
        if (sts.ovf_now) begin
          phase_nxt = PH_READY;
          state_nxt = S_ACCEPT;
        end else if (sts.fit) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: if (sts.walk_last) state_nxt = S_DRAIN;
      S_DRAIN: begin
        phase_nxt = PH_READY;
        state_nxt = S_ACCEPT;
      end
      S_FWAIT: state_nxt = S_OUT;
      S_OUT:   if (out_tready) state_nxt = S_ACCEPT;
      default: state_nxt = S_ACCEPT;
    endcase
  end

  always_comb begin
    in_tready       = (state_r == S_ACCEPT);
    out_tvalid      = (state_r == S_OUT);
    cmd             = '0;
    cmd.ready_phase = (phase_r == PH_READY);
    case (state_r)
      S_ACCEPT: begin
        cmd.load      = acc_in && (in_tuser == OP_LOAD);
        cmd.new_msg   = cmd.load && (phase_r != PH_LOAD);
        cmd.size_init = cmd.load && in_tlast;
        cmd.fetch     = acc_in && (in_tuser == OP_FETCH);
      end
      S_SIZE: begin
        cmd.set_ovf   = sts.ovf_now;
        cmd.walk_init = !sts.ovf_now && sts.fit;
      end
      S_WALK:  cmd.walk_step = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: sv/srt_datapath.sv
// datapath: config registers, message and result memories, grid sizing,
// spiral walk address generation and fetch result register; depends on srt_pkg
module srt_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [srt_pkg::IDX_W-1:0] cfg_index,
  input  logic [srt_pkg::CFG_W-1:0] cfg_data,
  input  logic [7:0]                in_tdata,
  input  srt_pkg::cmd_t             cmd,
  output srt_pkg::stat_bus_t        sts,
  output logic [7:0]                out_tdata,
  output logic                      out_tlast,
  output logic [1:0]                out_tuser
);
  import srt_pkg::*;

  logic             mode_r;
  logic [CFG_W-1:0] rows_r, cols_r;

  logic [7:0] msg_mem [CAPACITY];
  logic [7:0] res_mem [CAPACITY];
  logic [7:0] msg_q_r, res_q_r;

  logic [LEN_W-1:0] len_r, len_nxt, cnt_r, cnt_nxt, fcnt_r, fcnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CFG_W-1:0] r_r, r_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic [CFG_W-1:0] ti_r, ti_nxt, tj_r, tj_nxt;
  logic [CFG_W-1:0] top_r, top_nxt, bot_r, bot_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;
  dir_t             dir_r, dir_nxt;
  logic [LEN_W-1:0] p_r, p_nxt, k_r, k_nxt;

  logic             wr_pend_r, wr_zero_r;
  logic [ADDR_W-1:0] wr_addr_r;

  stat_t            ost_r, ost_nxt;
  logic             olast_r, olast_nxt;

  logic [LEN_W-1:0] base_len;
  logic             base_ovf, ld_wr;
  logic [LEN_W-1:0] rd_pos, wr_pos;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      rows_r <= CFG_W'(2);
      cols_r <= CFG_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[0];
        REG_ROWS: rows_r <= cfg_data;
        REG_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign base_len = cmd.new_msg ? '0 : len_r;
  assign base_ovf = cmd.new_msg ? 1'b0 : ovf_r;
  assign ld_wr    = cmd.load && (base_len < LEN_W'(CAPACITY));

  assign sts.ovf_now   = (cols_r == '0) || ovf_r || (acc_r > ACC_W'(CAPACITY));
  assign sts.fit       = (r_r >= rows_r) && (acc_r >= ACC_W'(len_r));
  assign sts.walk_last = (k_r == cnt_r - LEN_W'(1));

  // encrypt reads the grid at the spiral cell, decrypt writes it there
  assign rd_pos = mode_r ? k_r : p_r;
  assign wr_pos = mode_r ? p_r : k_r;

  always_comb begin
    len_nxt = len_r; ovf_nxt = ovf_r; cnt_nxt = cnt_r; fcnt_nxt = fcnt_r;
    r_nxt = r_r; acc_nxt = acc_r;
    ti_nxt = ti_r; tj_nxt = tj_r; top_nxt = top_r; bot_nxt = bot_r;
    lft_nxt = lft_r; rgt_nxt = rgt_r; dir_nxt = dir_r; p_nxt = p_r; k_nxt = k_r;
    ost_nxt = ost_r; olast_nxt = olast_r;

    if (cmd.load) begin
      ovf_nxt = base_ovf;
      len_nxt = base_len;
      if (ld_wr) len_nxt = base_len + LEN_W'(1);
      else       ovf_nxt = 1'b1;
    end
    if (cmd.size_init) begin
      r_nxt = '0; acc_nxt = '0;
    end
    if (!cmd.walk_init && !sts.fit) begin
      r_nxt   = r_r + CFG_W'(1);
      acc_nxt = acc_r + ACC_W'(cols_r);
    end
    if (cmd.size_init) begin
      r_nxt = '0; acc_nxt = '0;
    end
    if (cmd.set_ovf) ovf_nxt = 1'b1;
    if (cmd.walk_init) begin
      ti_nxt = '0; tj_nxt = '0; top_nxt = '0; lft_nxt = '0;
      bot_nxt = cols_r - CFG_W'(1);
      rgt_nxt = r_r - CFG_W'(1);
      dir_nxt = DIR_RIGHT; p_nxt = '0; k_nxt = '0;
      cnt_nxt = acc_r[LEN_W-1:0];
      fcnt_nxt = '0;
    end
    if (cmd.walk_step) begin
      k_nxt = k_r + LEN_W'(1);
      case (dir_r)
        DIR_RIGHT: begin
          if (tj_r == rgt_r) begin
            top_nxt = top_r + CFG_W'(1); dir_nxt = DIR_DOWN;
            ti_nxt = ti_r + CFG_W'(1); p_nxt = p_r + LEN_W'(1);
          end else begin
            tj_nxt = tj_r + CFG_W'(1); p_nxt = p_r + LEN_W'(cols_r);
          end
        end
        DIR_DOWN: begin
          if (ti_r == bot_r) begin
            rgt_nxt = rgt_r - CFG_W'(1); dir_nxt = DIR_LEFT;
            tj_nxt = tj_r - CFG_W'(1); p_nxt = p_r - LEN_W'(cols_r);
          end else begin
            ti_nxt = ti_r + CFG_W'(1); p_nxt = p_r + LEN_W'(1);
          end
        end
        DIR_LEFT: begin
          if (tj_r == lft_r) begin
            bot_nxt = bot_r - CFG_W'(1); dir_nxt = DIR_UP;
            ti_nxt = ti_r - CFG_W'(1); p_nxt = p_r - LEN_W'(1);
          end else begin
            tj_nxt = tj_r - CFG_W'(1); p_nxt = p_r - LEN_W'(cols_r);
          end
        end
        DIR_UP: begin
          if (ti_r == top_r) begin
            lft_nxt = lft_r + CFG_W'(1); dir_nxt = DIR_RIGHT;
            tj_nxt = tj_r + CFG_W'(1); p_nxt = p_r + LEN_W'(cols_r);
          end else begin
            ti_nxt = ti_r - CFG_W'(1); p_nxt = p_r - LEN_W'(1);
          end
        end
        default: ;
      endcase
    end
    if (cmd.fetch) begin
      olast_nxt = 1'b0;
      if (cmd.ready_phase && ovf_r) begin
        ost_nxt = ST_OVF;
      end else if (!cmd.ready_phase || fcnt_r >= cnt_r) begin
        ost_nxt = ST_EMPTY;
      end else begin
        ost_nxt   = ST_OK;
        olast_nxt = (fcnt_r + LEN_W'(1) == cnt_r);
        fcnt_nxt  = fcnt_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; ovf_r <= 1'b0; cnt_r <= '0; fcnt_r <= '0;
      r_r <= '0; acc_r <= '0;
      ti_r <= '0; tj_r <= '0; top_r <= '0; bot_r <= '0; lft_r <= '0; rgt_r <= '0;
      dir_r <= DIR_RIGHT; p_r <= '0; k_r <= '0;
      wr_pend_r <= 1'b0;
      ost_r <= ST_EMPTY; olast_r <= 1'b0;
    end else begin
      len_r <= len_nxt; ovf_r <= ovf_nxt; cnt_r <= cnt_nxt; fcnt_r <= fcnt_nxt;
      r_r <= r_nxt; acc_r <= acc_nxt;
      ti_r <= ti_nxt; tj_r <= tj_nxt; top_r <= top_nxt; bot_r <= bot_nxt;
      lft_r <= lft_nxt; rgt_r <= rgt_nxt; dir_r <= dir_nxt; p_r <= p_nxt; k_r <= k_nxt;
      wr_pend_r <= cmd.walk_step;
      ost_r <= ost_nxt; olast_r <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      wr_addr_r <= wr_pos[ADDR_W-1:0];
      wr_zero_r <= (rd_pos >= len_r);
    end
  end

  // message memory
  always_ff @(posedge clk) begin
    if (ld_wr) msg_mem[base_len[ADDR_W-1:0]] <= in_tdata;
    if (cmd.walk_step) msg_q_r <= msg_mem[rd_pos[ADDR_W-1:0]];
  end

  // result memory
  always_ff @(posedge clk) begin
    if (wr_pend_r) res_mem[wr_addr_r] <= wr_zero_r ? 8'd0 : msg_q_r;
    if (cmd.fetch) res_q_r <= res_mem[fcnt_r[ADDR_W-1:0]];
  end

  assign out_tdata = (ost_r == ST_OK) ? res_q_r : 8'd0;
  assign out_tlast = olast_r;
  assign out_tuser = ost_r;

endmodule

// File: sv/spiral_route_transposition_top.sv
// top level of the spiral route transposition block
// instantiates srt_ctrl and srt_datapath; depends on srt_pkg
//
// the byte marked last starts a sizing loop up to max(rows,
// ceil(length/columns)) rows (one add per cycle, cut short once the grid passes
// capacity, columns is zero or the message overflowed), then the spiral walk
// moves one cell per cycle through the single-port message and result memories
// over all rows x columns cells, and a drain state ends the last write. each
// fetch goes through accept, registered result memory read, then the result
// transaction waits in the output register until taken. no input is taken while
// sizing, walking or fetching; configuration writes are taken at any time
module spiral_route_transposition_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // data_byte
  input  logic                      in_tuser,   // opcode
  input  logic                      in_tlast,   // last
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // out_byte
  output logic [1:0]                out_tuser,  // status
  output logic                      out_tlast,  // out_last
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [srt_pkg::IDX_W-1:0] cfg_index,
  input  logic [srt_pkg::CFG_W-1:0] cfg_data
);
  import srt_pkg::*;

  cmd_t      cmd;
  stat_bus_t sts;

  // register writes never stall
  assign cfg_ready = 1'b1;

  srt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  srt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// File: sv/srt_checker.sv
// port-level checks of the spiral route transposition block
// depends on srt_pkg and spiral_route_transposition_top ports; bound below
module srt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import srt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 8'd0 && !out_tlast)
    else $error("error result carries data");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is held");

  a_fetch_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> ##1 out_tvalid)
    else $error("fetch result late");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("bad status");

endmodule

bind spiral_route_transposition_top srt_checker u_srt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: test/tb_top.sv
// self-checking testbench of the spiral route transposition block
// drives load and fetch transactions, predicts each result byte, compares the results
// depends on srt_pkg and spiral_route_transposition_top
module tb_top;
  import srt_pkg::*;

  localparam int CAP        = 1024;
  localparam int WDOG_LIMIT = 12000;  // longest quiet stretch: sizing, walk, settle
  localparam int SETTLE     = 3300;   // worst sizing loop plus walk plus drain

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    stat_t      status;
  } cipher_out_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] x_data;
    logic       x_last;
    stat_t      x_status;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  always #10 clk = ~clk;

  spiral_route_transposition_top dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // predictor state
  logic        p_mode;
  logic [10:0] p_rows, p_cols;
  logic [7:0]  msg_mem [CAP];
  logic [7:0]  cipher_mem [CAP];
  int          msg_len, cipher_len, fetch_pos;
  logic        too_big;
  phase_t      p_phase;

  cipher_out_t expected_bytes[$];
  int          fails = 0;
  int          items = 0;
  bit          quiet = 0;   // no idling in the closing stretch
  bit          calm  = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  // one cell of the spiral: k is the walk index, (ti, tj) the transposed cell
  function automatic void place_cell(int k, int ti, int tj);
    int p;
    p = tj * p_cols + ti;
    if (p >= CAP || k >= CAP) return;
    if (p_mode == 1'b0) cipher_mem[k] = (p < msg_len) ? msg_mem[p] : 8'h00;
    else                cipher_mem[p] = (k < msg_len) ? msg_mem[k] : 8'h00;
  endfunction

  function automatic void build_cipher();
    int grid, cols, cells, k, i, top, bot, lft, rgt;
    cols = p_cols;
    cipher_len = 0;
    k = 0;
    if (cols == 0) begin
      too_big = 1'b1;
      return;
    end
    grid = p_rows;
    if (grid * cols < msg_len) grid = (msg_len + cols - 1) / cols;
    cells = grid * cols;
    if (too_big || cells > CAP) begin
      too_big = 1'b1;
      return;
    end
    cipher_len = cells;
    top = 0; bot = cols - 1; lft = 0; rgt = grid - 1;
    while (top <= bot && lft <= rgt) begin
      for (i = lft; i <= rgt; i++) begin place_cell(k, top, i); k++; end
      top++;
      if (top <= bot) begin
        for (i = top; i <= bot; i++) begin place_cell(k, i, rgt); k++; end
        rgt--;
      end
      if (top <= bot) begin
        for (i = rgt; i >= lft; i--) begin place_cell(k, bot, i); k++; end
        bot--;
      end
      if (lft <= rgt) begin
        for (i = bot; i >= top; i--) begin place_cell(k, i, lft); k++; end
        lft++;
      end
    end
  endfunction

  // advances the predictor by one accepted transaction, returns 1 with a result
  function automatic bit predict_cipher(logic op, logic [7:0] data, logic last,
                                        output cipher_out_t res);
    res = '{data: 8'h00, last: 1'b0, status: ST_OK};
    if (op == OP_LOAD) begin
      if (p_phase != PH_LOAD) begin
        msg_len = 0; too_big = 1'b0; cipher_len = 0; fetch_pos = 0;
        p_phase = PH_LOAD;
      end
      if (msg_len < CAP) begin
        msg_mem[msg_len] = data;
        msg_len++;
      end else begin
        too_big = 1'b1;
      end
      if (last) begin
        build_cipher();
        fetch_pos = 0;
        p_phase = PH_READY;
      end
      return 0;
    end
    if (p_phase == PH_READY && too_big) res.status = ST_OVF;
    else if (p_phase != PH_READY || fetch_pos >= cipher_len) res.status = ST_EMPTY;
    else begin
      res.data = cipher_mem[fetch_pos];
      res.last = (fetch_pos + 1 == cipher_len);
      fetch_pos++;
    end
    return 1;
  endfunction

  // one input transaction, sometimes with a random idle burst in front of it
  task automatic send(logic op, logic [7:0] data, logic last,
                      bit typed = 0, cipher_out_t want = '0);
    cipher_out_t res;
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items++;
    if (predict_cipher(op, data, last, res)) begin
      if (typed) res = want;
      expected_bytes = {expected_bytes, res};
    end
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE: p_mode = val[0];
      REG_ROWS: p_rows = val;
      REG_COLS: p_cols = val;
      default: ;
    endcase
  endtask

  // let the block drain and finish any walk before touching the registers
  task automatic settle_then_config(logic m, logic [10:0] r, logic [10:0] c);
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_MODE, {10'd0, m});
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
  endtask

  // load a message of random bytes, then fetch the whole result and a bit more
  task automatic run_message(int len, int extra);
    int n;
    for (int i = 0; i < len; i++) send(OP_LOAD, 8'($urandom), i == len - 1);
    n = too_big ? 2 : cipher_len;
    for (int i = 0; i < n + extra; i++) send(OP_FETCH, 8'($urandom), 1'($urandom));
  endtask

  // load a message of random bytes, then fetch only the first few result bytes
  task automatic run_partial(int len, int fetches);
    for (int i = 0; i < len; i++) send(OP_LOAD, 8'($urandom), i == len - 1);
    for (int i = 0; i < fetches; i++) send(OP_FETCH, 8'($urandom), 1'($urandom));
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report("unexpected result", 32'({out_tdata, out_tlast, out_tuser}), 32'd0);
      end else begin
        cipher_out_t w;
        w = expected_bytes.pop_front();
        if (out_tuser !== w.status) report("status", 32'(out_tuser), 32'(w.status));
        if (out_tdata !== w.data)   report("byte", 32'(out_tdata), 32'(w.data));
        if (out_tlast !== w.last)   report("last", 32'(out_tlast), 32'(w.last));
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("spiral_route_transposition_top: mismatch");
      $finish;
    end
  end

  // directed rows: after reset the 2x2 encrypt grid reads m0 m2 m3 m1
  vec_t dir_rows[] = '{
    '{OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_EMPTY},
    '{OP_LOAD,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_LOAD,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_LOAD,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_LOAD,  8'h7F, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_FETCH, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, ST_OK},
    '{OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h80, 1'b0, ST_OK},
    '{OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h7F, 1'b0, ST_OK},
    '{OP_FETCH, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1, ST_OK},
    // after the final result byte
    '{OP_FETCH, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_EMPTY},
    // fetch while a message is still loading
    '{OP_LOAD,  8'h55, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_FETCH, 8'hAA, 1'b1, 1'b1, 8'h00, 1'b0, ST_EMPTY},
    '{OP_LOAD,  8'hAA, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_FETCH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_FETCH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    // new message while a result is half read
    '{OP_LOAD,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_FETCH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK},
    '{OP_FETCH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK}
  };

  initial begin
    int len;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = OP_LOAD;
    in_tlast   = 1'b0;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_MODE;
    cfg_data   = '0;
    p_mode = 1'b0; p_rows = 11'd2; p_cols = 11'd2;
    msg_len = 0; cipher_len = 0; fetch_pos = 0; too_big = 1'b0;
    p_phase = PH_IDLE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send(dir_rows[i].op, dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
           '{data: dir_rows[i].x_data, last: dir_rows[i].x_last,
             status: dir_rows[i].x_status});

    // register settings: decrypt, single cell, full capacity grids (first bytes
    // only), oversize grids, zero columns, and one message longer than capacity
    settle_then_config(1'b1, 11'd2, 11'd2);      run_message(4, 1);
    settle_then_config(1'b0, 11'd1, 11'd1);      run_message(5, 1);
    settle_then_config(1'b1, 11'd1, 11'd3);      run_message(7, 1);
    settle_then_config(1'b0, 11'd32, 11'd32);    run_partial(10, 40);
    settle_then_config(1'b1, 11'd1024, 11'd1);   run_partial(3, 40);
    settle_then_config(1'b0, 11'd2047, 11'd1);   run_message(3, 1);
    settle_then_config(1'b1, 11'd1, 11'd2047);   run_message(2, 1);
    settle_then_config(1'b0, 11'd3, 11'd0);      run_message(4, 1);
    settle_then_config(1'b0, 11'd1, 11'd1024);   run_message(1025, 1);

    // random settings and messages, mostly well formed, with some noise
    while (items < 1550) begin
      if ($urandom_range(0, 7) == 0)
        settle_then_config(1'($urandom), 11'($urandom_range(1, 12)),
                           11'($urandom_range(1, 12)));
      calm  = ($urandom_range(0, 4) == 0);
      quiet = (items > 1350);
      len = $urandom_range(1, 30);
      case ($urandom_range(0, 9))
        0: send(OP_FETCH, 8'($urandom), 1'($urandom));          // stray fetch
        1: begin                                                // cut short
          for (int i = 0; i < len; i++) send(OP_LOAD, 8'($urandom), i == len - 1);
          repeat ($urandom_range(0, 3)) send(OP_FETCH, 8'($urandom), 1'($urandom));
        end
        default: run_message(len, $urandom_range(0, 2));
      endcase
    end

    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("spiral_route_transposition_top: match");
    else $display("spiral_route_transposition_top: mismatch");
    $finish;
  end

endmodule
